// ===== hw/rtl/spiadc_pkg.sv =====
package spiadc_pkg;

    localparam int DATA_BITS  = 10;
    localparam int CMD_BITS   = 5;
    localparam int DELAY_W    = 16;
    localparam int CH_W       = 3;
    localparam int NCH_W      = 4;
    localparam int BIT_IDX_W  = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]            CMD_HEAD       = 8'h18;
    localparam logic [NCH_W-1:0]      MAX_CHANNELS   = NCH_W'(8);
    localparam logic [NCH_W-1:0]      RESET_CHANNELS = NCH_W'(4);
    localparam logic [DELAY_W-1:0]    RESET_HALF     = DELAY_W'(1);
    localparam logic [BIT_IDX_W-1:0]  CMD_LAST_BIT   = BIT_IDX_W'(CMD_BITS - 1);
    localparam logic [BIT_IDX_W-1:0]  READ_BITS      = BIT_IDX_W'(DATA_BITS);

    localparam logic [CFG_IDX_W-1:0]  REG_SCAN_CHANNELS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0]  REG_HALF_PERIOD   = CFG_IDX_W'(1);

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_CS_SETUP  = 8'b0000_0010,
        PH_CMD_SETUP = 8'b0000_0100,
        PH_CMD_HIGH  = 8'b0000_1000,
        PH_CMD_LOW   = 8'b0001_0000,
        PH_RD_HIGH   = 8'b0010_0000,
        PH_RD_LOW    = 8'b0100_0000,
        PH_GAP       = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic                 cs_n;
        logic                 sclk;
        logic                 mosi;
        logic                 busy_res;
        logic                 sample_valid;
        logic [CH_W-1:0]      sample_channel;
        logic [DATA_BITS-1:0] sample_value;
        logic                 scan_done;
    } tick_result_t;

    // command bit for a given channel, bit position counted from the lsb
    function automatic logic cmd_bit(input logic [CH_W-1:0] ch, input logic [2:0] pos);
        logic [7:0] cmd;
        cmd = CMD_HEAD | {{(8 - CH_W){1'b0}}, ch};
        return cmd[pos];
    endfunction

endpackage

// ===== hw/rtl/spiadc_in_if.sv =====
interface spiadc_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic miso;

    modport source (output valid, output start_req, output miso, input ready);
    modport sink (input valid, input start_req, input miso, output ready);
endinterface

// ===== hw/rtl/spiadc_out_if.sv =====
interface spiadc_out_if;
    import spiadc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 cs_n;
    logic                 sclk;
    logic                 mosi;
    logic                 busy_res;
    logic                 sample_valid;
    logic [CH_W-1:0]      sample_channel;
    logic [DATA_BITS-1:0] sample_value;
    logic                 scan_done;

    modport source (output valid, output cs_n, output sclk, output mosi, output busy_res,
                    output sample_valid, output sample_channel, output sample_value,
                    output scan_done, input ready);
    modport sink (input valid, input cs_n, input sclk, input mosi, input busy_res,
                  input sample_valid, input sample_channel, input sample_value,
                  input scan_done, output ready);
endinterface

// ===== hw/rtl/spiadc_cfg_if.sv =====
interface spiadc_cfg_if;
    import spiadc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/spi_adc_channel_scanner.sv =====
// SPI master that scans channels 0 to scan_channels-1 of an 8-channel 10-bit serial ADC.
// Each input transaction is one tick of the serial sequencer (start_req and the miso level);
// each tick yields exactly one output transaction with the pin levels after that tick
// (cs_n, sclk, mosi), busy_res, and on the tick chip select rises after a channel the
// sample, its channel and the end-of-scan flag. A transaction is taken every clock cycle:
// the sequencer state and the output register both advance on an accepted tick, and a new
// tick is accepted whenever the output register is empty or being drained in the same
// cycle, so out_ch.ready stalls are the only thing that holds off the input. Every pin
// phase lasts half_period_ticks ticks, so one channel takes 38 phases (chip select setup,
// three per command bit, two per read clock) plus a one-phase gap with chip select high.
// Registers are written through cfg (index 0 scan_channels, index 1 half_period_ticks)
// by the user only while the block is idle (not enforced by the block); cfg is always ready.
module spi_adc_channel_scanner (
    input  logic         clk,
    input  logic         rst_n,
    spiadc_in_if.sink    in_ch,
    spiadc_out_if.source out_ch,
    spiadc_cfg_if.sink   cfg
);
    import spiadc_pkg::*;

    // configuration registers
    logic [NCH_W-1:0]   scan_channels_reg;
    logic [DELAY_W-1:0] half_period_reg;

    // output register
    logic               out_valid_reg;
    tick_result_t       out_data_reg;

    tick_result_t       tick_result;
    logic               in_accept;

    // take a tick when the output slot is free or emptied this cycle
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_channels_reg <= RESET_CHANNELS;
            half_period_reg   <= RESET_HALF;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SCAN_CHANNELS: scan_channels_reg <= cfg.data[NCH_W-1:0];
                REG_HALF_PERIOD:   half_period_reg   <= cfg.data[DELAY_W-1:0];
                default:           ;
            endcase
        end
    end

    // pin sequencer, advances one tick per accepted transaction
    spiadc_seq u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .step_en           (in_accept),
        .start_req         (in_ch.start_req),
        .miso              (in_ch.miso),
        .scan_channels     (scan_channels_reg),
        .half_period_ticks (half_period_reg),
        .result            (tick_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload only loads with a new tick
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= tick_result;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.cs_n           = out_data_reg.cs_n;
    assign out_ch.sclk           = out_data_reg.sclk;
    assign out_ch.mosi           = out_data_reg.mosi;
    assign out_ch.busy_res       = out_data_reg.busy_res;
    assign out_ch.sample_valid   = out_data_reg.sample_valid;
    assign out_ch.sample_channel = out_data_reg.sample_channel;
    assign out_ch.sample_value   = out_data_reg.sample_value;
    assign out_ch.scan_done      = out_data_reg.scan_done;

endmodule

// ===== hw/rtl/spiadc_seq.sv =====
module spiadc_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  logic                            start_req,
    input  logic                            miso,
    input  logic [spiadc_pkg::NCH_W-1:0]    scan_channels,
    input  logic [spiadc_pkg::DELAY_W-1:0]  half_period_ticks,
    output spiadc_pkg::tick_result_t        result
);
    import spiadc_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [DELAY_W-1:0]     delay_reg, delay_next;
    logic [BIT_IDX_W-1:0]   bit_reg, bit_next;
    logic [CH_W-1:0]        ch_reg, ch_next;
    logic [DATA_BITS-1:0]   shift_reg, shift_next;
    logic                   cs_n_reg, cs_n_next;
    logic                   sclk_reg, sclk_next;
    logic                   mosi_reg, mosi_next;

    logic [DELAY_W-1:0]     half;
    logic [NCH_W-1:0]       nch;
    logic                   last_ch;
    logic [BIT_IDX_W-1:0]   bit_dec;

    assign half    = (half_period_ticks == '0) ? DELAY_W'(1) : half_period_ticks;
    assign nch     = (scan_channels == '0) ? NCH_W'(1) :
                     ((scan_channels > MAX_CHANNELS) ? MAX_CHANNELS : scan_channels);
    assign last_ch = ({1'b0, ch_reg} + NCH_W'(1)) >= nch;
    assign bit_dec = bit_reg - BIT_IDX_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        delay_next = delay_reg;
        bit_next   = bit_reg;
        ch_next    = ch_reg;
        shift_next = shift_reg;
        cs_n_next  = cs_n_reg;
        sclk_next  = sclk_reg;
        mosi_next  = mosi_reg;
        result     = '0;

        if (phase_reg == PH_IDLE)
        begin
            if (start_req)
            begin
                ch_next    = '0;
                shift_next = '0;
                bit_next   = '0;
                cs_n_next  = 1'b0;
                sclk_next  = 1'b0;
                mosi_next  = 1'b0;
                phase_next = PH_CS_SETUP;
                delay_next = DELAY_W'(1);
            end
        end
        else if (delay_reg < half)
        begin
            delay_next = delay_reg + DELAY_W'(1);
        end
        else
        begin
            delay_next = DELAY_W'(1);
            case (phase_reg)
                PH_CS_SETUP:
                begin
                    bit_next   = CMD_LAST_BIT;
                    mosi_next  = cmd_bit(ch_reg, CMD_LAST_BIT[2:0]);
                    phase_next = PH_CMD_SETUP;
                end
                PH_CMD_SETUP:
                begin
                    sclk_next  = 1'b1;
                    phase_next = PH_CMD_HIGH;
                end
                PH_CMD_HIGH:
                begin
                    sclk_next  = 1'b0;
                    phase_next = PH_CMD_LOW;
                end
                PH_CMD_LOW:
                begin
                    if (bit_reg != '0)
                    begin
                        bit_next   = bit_dec;
                        mosi_next  = cmd_bit(ch_reg, bit_dec[2:0]);
                        phase_next = PH_CMD_SETUP;
                    end
                    else
                    begin
                        bit_next   = READ_BITS;
                        shift_next = '0;
                        sclk_next  = 1'b1;
                        phase_next = PH_RD_HIGH;
                    end
                end
                PH_RD_HIGH:
                begin
                    sclk_next  = 1'b0;
                    phase_next = PH_RD_LOW;
                end
                PH_RD_LOW:
                begin
                    if (bit_reg != '0)
                    begin
                        bit_next   = bit_dec;
                        sclk_next  = 1'b1;
                        phase_next = PH_RD_HIGH;
                    end
                    else
                    begin
                        cs_n_next             = 1'b1;
                        sclk_next             = 1'b0;
                        mosi_next             = 1'b0;
                        result.sample_valid   = 1'b1;
                        result.sample_channel = ch_reg;
                        result.sample_value   = shift_reg;
                        if (last_ch)
                        begin
                            result.scan_done = 1'b1;
                            phase_next       = PH_IDLE;
                            delay_next       = '0;
                            ch_next          = '0;
                        end
                        else
                        begin
                            phase_next = PH_GAP;
                        end
                    end
                end
                PH_GAP:
                begin
                    ch_next    = ch_reg + CH_W'(1);
                    shift_next = '0;
                    cs_n_next  = 1'b0;
                    sclk_next  = 1'b0;
                    mosi_next  = 1'b0;
                    phase_next = PH_CS_SETUP;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    delay_next = '0;
                    cs_n_next  = 1'b1;
                    sclk_next  = 1'b0;
                    mosi_next  = 1'b0;
                end
            endcase
        end

        // miso is taken on the last tick of each clock-high read phase, null bit skipped
        if (phase_next == PH_RD_HIGH && delay_next == half && bit_next != READ_BITS)
        begin
            shift_next = {shift_next[DATA_BITS-2:0], miso};
        end

        result.cs_n     = cs_n_next;
        result.sclk     = sclk_next;
        result.mosi     = mosi_next;
        result.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            delay_reg <= '0;
            bit_reg   <= '0;
            ch_reg    <= '0;
            shift_reg <= '0;
            cs_n_reg  <= 1'b1;
            sclk_reg  <= 1'b0;
            mosi_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            delay_reg <= delay_next;
            bit_reg   <= bit_next;
            ch_reg    <= ch_next;
            shift_reg <= shift_next;
            cs_n_reg  <= cs_n_next;
            sclk_reg  <= sclk_next;
            mosi_reg  <= mosi_next;
        end
    end

endmodule
